FILE: rtl/fixed_point_alu_assert.svh
// Assertion macros for the fixed-point ALU.
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

// Same-cycle implication, checked at every clock edge out of reset.
`define FPA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication on a past value of an expression, read with $past at the given depth.
`define FPA_ASSERT_PAST(label, ante, expr, depth, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> $past(expr, depth)) else $error(msg);

`endif

FILE: rtl/fpa_pkg.sv
// Types, codes and helpers shared by the fixed-point ALU modules.
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;
    localparam int NUM_W     = DATA_W + FRAC_BITS + 2;
    localparam int DEN_W     = DATA_W + 1;
    localparam int REM_W     = DEN_W;
    localparam int FI_W      = DATA_W + FRAC_BITS;
    localparam int DIV_STEPS = DATA_W;
    localparam int PIPE_LAT  = DIV_STEPS + 4;

    localparam logic [3:0] FN_ADD      = 4'd0;
    localparam logic [3:0] FN_SUB      = 4'd1;
    localparam logic [3:0] FN_MUL      = 4'd2;
    localparam logic [3:0] FN_DIV      = 4'd3;
    localparam logic [3:0] FN_GT       = 4'd4;
    localparam logic [3:0] FN_LT       = 4'd5;
    localparam logic [3:0] FN_GE       = 4'd6;
    localparam logic [3:0] FN_LE       = 4'd7;
    localparam logic [3:0] FN_EQ       = 4'd8;
    localparam logic [3:0] FN_NE       = 4'd9;
    localparam logic [3:0] FN_MIN      = 4'd10;
    localparam logic [3:0] FN_MAX      = 4'd11;
    localparam logic [3:0] FN_INC      = 4'd12;
    localparam logic [3:0] FN_DEC      = 4'd13;
    localparam logic [3:0] FN_TO_INT   = 4'd14;
    localparam logic [3:0] FN_FROM_INT = 4'd15;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [3:0]               func;
        logic signed [DATA_W-1:0] operand_a;
        logic signed [DATA_W-1:0] operand_b;
    } in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     truth;
        logic [1:0]               status;
    } out_t;

    typedef struct packed {
        out_t res;
        logic is_div;
        logic neg;
        logic ovf;
    } side_t;

    typedef struct packed {
        side_t             side;
        logic [DEN_W-1:0]  den;
        logic [REM_W-1:0]  rem;
        logic [DATA_W-1:0] low;
    } div_word_t;

    // Clip a signed value one bit wider than the result.
    function automatic out_t sat_s33(input logic [DATA_W:0] v);
        out_t r;
        r.truth = 1'b0;
        if (v[DATA_W] != v[DATA_W-1])
        begin
            r.value  = v[DATA_W] ? VAL_MIN : VAL_MAX;
            r.status = ST_OVF;
        end
        else
        begin
            r.value  = v[DATA_W-1:0];
            r.status = ST_OK;
        end
        return r;
    endfunction

    // Apply a sign to a magnitude and clip to the signed range.
    function automatic out_t sat_mag(input logic [63:0] mag, input logic neg,
                                     input logic ovf_in);
        out_t r;
        logic ovf;
        r.truth = 1'b0;
        ovf = ovf_in || (neg ? (mag > 64'h8000_0000) : (mag > 64'h7FFF_FFFF));
        if (ovf)
        begin
            r.value  = neg ? VAL_MIN : VAL_MAX;
            r.status = ST_OVF;
        end
        else
        begin
            r.value  = neg ? (32'd0 - mag[DATA_W-1:0]) : mag[DATA_W-1:0];
            r.status = ST_OK;
        end
        return r;
    endfunction

endpackage

FILE: rtl/fixed_point_alu.sv
// Top level of the pipelined signed fixed-point ALU.
//
//  channel   ports                   handshake
//  -------   ---------------------   -----------------------------------
//  command   start, busy, cmd        taken when start is high, busy low
//  result    done, result            one cycle per item, done marks it
//
// Every item passes the input, operand decode and rounding stages, the 32-stage
// restoring divider and the result register; all functions share that path.
// A new item may enter every cycle; busy stays low.
// Reset clears the valid bits of every stage; data registers are not reset.
// The receiver cannot stall, so no stage ever holds.
`include "fixed_point_alu_assert.svh"

module fixed_point_alu (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  fpa_pkg::in_t   cmd,
    output logic           done,
    output fpa_pkg::out_t  result
);

    // input stage
    logic          valid1_reg;
    fpa_pkg::in_t  cmd1_reg;

    // operand decode stage
    logic                            valid2_reg;
    fpa_pkg::out_t                   res2_reg;
    fpa_pkg::out_t                   res2_next;
    logic [63:0]                     prod2_reg;
    logic [fpa_pkg::NUM_W-1:0]       num2_reg;
    logic [fpa_pkg::NUM_W-1:0]       num2_next;
    logic [fpa_pkg::DEN_W-1:0]       den2_reg;
    logic                            neg2_reg;
    logic                            is_mul2_reg;
    logic                            is_div2_reg;
    logic                            is_div2_next;

    // rounding and divider setup stage
    logic                 valid3_reg;
    fpa_pkg::div_word_t   word3_reg;
    fpa_pkg::div_word_t   word3_next;

    // divider output and result register
    logic                 valid_div;
    fpa_pkg::div_word_t   word_div;
    logic                 done_reg;
    fpa_pkg::out_t        result_reg;
    fpa_pkg::out_t        result_next;

    logic signed [fpa_pkg::DATA_W-1:0] a1;
    logic signed [fpa_pkg::DATA_W-1:0] b1;
    logic [fpa_pkg::DATA_W-1:0]        mag_a;
    logic [fpa_pkg::DATA_W-1:0]        mag_b;
    logic [fpa_pkg::FI_W-1:0]          fi;
    logic                              a_lt_b;
    logic                              a_eq_b;
    logic [63:0]                       rounded;

    always_comb
    begin
        a1     = cmd1_reg.operand_a;
        b1     = cmd1_reg.operand_b;
        mag_a  = a1[fpa_pkg::DATA_W-1] ? (32'd0 - a1) : a1;
        mag_b  = b1[fpa_pkg::DATA_W-1] ? (32'd0 - b1) : b1;
        a_lt_b = a1 < b1;
        a_eq_b = a1 == b1;
        fi     = {a1, {fpa_pkg::FRAC_BITS{1'b0}}};
        // 2n + d, the numerator of the rounded quotient
        num2_next = fpa_pkg::NUM_W'({mag_a, {(fpa_pkg::FRAC_BITS + 1){1'b0}}})
                  + fpa_pkg::NUM_W'(mag_b);
        is_div2_next = 1'b0;

        res2_next.value  = '0;
        res2_next.truth  = 1'b0;
        res2_next.status = fpa_pkg::ST_OK;
        case (cmd1_reg.func)
            fpa_pkg::FN_ADD:
                res2_next = fpa_pkg::sat_s33({a1[31], a1} + {b1[31], b1});
            fpa_pkg::FN_SUB:
                res2_next = fpa_pkg::sat_s33({a1[31], a1} - {b1[31], b1});
            fpa_pkg::FN_MUL:
                res2_next.status = fpa_pkg::ST_OK;
            fpa_pkg::FN_DIV:
            begin
                if (b1 == '0)
                begin
                    res2_next.status = fpa_pkg::ST_DIV0;
                end
                else
                begin
                    is_div2_next = 1'b1;
                end
            end
            fpa_pkg::FN_GT:  res2_next.truth = !a_lt_b && !a_eq_b;
            fpa_pkg::FN_LT:  res2_next.truth = a_lt_b;
            fpa_pkg::FN_GE:  res2_next.truth = !a_lt_b;
            fpa_pkg::FN_LE:  res2_next.truth = a_lt_b || a_eq_b;
            fpa_pkg::FN_EQ:  res2_next.truth = a_eq_b;
            fpa_pkg::FN_NE:  res2_next.truth = !a_eq_b;
            fpa_pkg::FN_MIN: res2_next.value = a_lt_b ? a1 : b1;
            fpa_pkg::FN_MAX: res2_next.value = (!a_lt_b && !a_eq_b) ? a1 : b1;
            fpa_pkg::FN_INC:
                res2_next = fpa_pkg::sat_s33({a1[31], a1} + 33'd1);
            fpa_pkg::FN_DEC:
                res2_next = fpa_pkg::sat_s33({a1[31], a1} - 33'd1);
            fpa_pkg::FN_TO_INT:
                res2_next.value = a1 >>> fpa_pkg::FRAC_BITS;
            fpa_pkg::FN_FROM_INT:
            begin
                if (fi[fpa_pkg::FI_W-1:fpa_pkg::DATA_W-1]
                    != {(fpa_pkg::FRAC_BITS + 1){a1[fpa_pkg::DATA_W-1]}})
                begin
                    res2_next.value  = a1[fpa_pkg::DATA_W-1] ? fpa_pkg::VAL_MIN
                                                             : fpa_pkg::VAL_MAX;
                    res2_next.status = fpa_pkg::ST_OVF;
                end
                else
                begin
                    res2_next.value = fi[fpa_pkg::DATA_W-1:0];
                end
            end
            default:
                res2_next.status = fpa_pkg::ST_OK;
        endcase
    end

    always_comb
    begin
        rounded = (prod2_reg + (64'd1 << (fpa_pkg::FRAC_BITS - 1))) >> fpa_pkg::FRAC_BITS;
        word3_next.side.res    = is_mul2_reg ? fpa_pkg::sat_mag(rounded, neg2_reg, 1'b0)
                                             : res2_reg;
        word3_next.side.is_div = is_div2_reg;
        word3_next.side.neg    = neg2_reg;
        // a quotient of 2^32 or more can only saturate
        word3_next.side.ovf    = (num2_reg >> fpa_pkg::DATA_W)
                               >= fpa_pkg::NUM_W'(den2_reg);
        word3_next.den = den2_reg;
        word3_next.rem = fpa_pkg::REM_W'(num2_reg >> fpa_pkg::DATA_W);
        word3_next.low = num2_reg[fpa_pkg::DATA_W-1:0];
    end

    always_comb
    begin
        if (word_div.side.is_div)
        begin
            result_next = fpa_pkg::sat_mag(64'(word_div.low), word_div.side.neg,
                                           word_div.side.ovf);
        end
        else
        begin
            result_next = word_div.side.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            valid1_reg <= start && !busy;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
            done_reg   <= valid_div;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd1_reg    <= cmd;
        res2_reg    <= res2_next;
        prod2_reg   <= 64'(mag_a) * 64'(mag_b);
        num2_reg    <= num2_next;
        den2_reg    <= {mag_b, 1'b0};
        neg2_reg    <= a1[fpa_pkg::DATA_W-1] ^ b1[fpa_pkg::DATA_W-1];
        is_mul2_reg <= cmd1_reg.func == fpa_pkg::FN_MUL;
        is_div2_reg <= is_div2_next;
        word3_reg   <= word3_next;
        result_reg  <= result_next;
    end

    fpa_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (valid3_reg),
        .word_in   (word3_reg),
        .valid_out (valid_div),
        .word_out  (word_div)
    );

    assign busy   = 1'b0;
    assign done   = done_reg;
    assign result = result_reg;

    `FPA_ASSERT_PAST(a_done_latency, done, start && !busy, fpa_pkg::PIPE_LAT,
        "result without item")
    `FPA_ASSERT_NOW(a_div0_zero, done && result.status == fpa_pkg::ST_DIV0,
        result.value == '0 && !result.truth, "div by zero value")
    `FPA_ASSERT_NOW(a_truth_clean, done && result.truth,
        result.value == '0 && result.status == fpa_pkg::ST_OK, "truth with value")
    `FPA_ASSERT_NOW(a_status_code, done, result.status != 2'd3, "bad status")

endmodule

FILE: rtl/fpa_div_step.sv
// One restoring-division stage: one quotient bit per clock.
module fpa_div_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  fpa_pkg::div_word_t word_in,
    output logic              valid_out,
    output fpa_pkg::div_word_t word_out
);

    logic                        valid_reg;
    fpa_pkg::div_word_t          word_reg;
    fpa_pkg::div_word_t          word_next;
    logic [fpa_pkg::REM_W:0]     trial;
    logic [fpa_pkg::REM_W:0]     diff;
    logic                        fits;

    always_comb
    begin
        trial = {word_in.rem, word_in.low[fpa_pkg::DATA_W-1]};
        diff  = trial - {1'b0, word_in.den};
        fits  = trial >= {1'b0, word_in.den};
        word_next      = word_in;
        word_next.rem  = fits ? diff[fpa_pkg::REM_W-1:0] : trial[fpa_pkg::REM_W-1:0];
        // shift the next dividend bit out, the quotient bit in
        word_next.low  = {word_in.low[fpa_pkg::DATA_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign valid_out = valid_reg;
    assign word_out  = word_reg;

endmodule

FILE: rtl/fpa_divider.sv
// Pipelined divider: a chain of one-bit restoring stages.
module fpa_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  fpa_pkg::div_word_t word_in,
    output logic              valid_out,
    output fpa_pkg::div_word_t word_out
);

    logic               valid_chain [0:fpa_pkg::DIV_STEPS];
    fpa_pkg::div_word_t word_chain  [0:fpa_pkg::DIV_STEPS];

    assign valid_chain[0] = valid_in;
    assign word_chain[0]  = word_in;

    for (genvar i = 0; i < fpa_pkg::DIV_STEPS; i++)
    begin : g_step
        fpa_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_chain[i]),
            .word_in   (word_chain[i]),
            .valid_out (valid_chain[i+1]),
            .word_out  (word_chain[i+1])
        );
    end

    assign valid_out = valid_chain[fpa_pkg::DIV_STEPS];
    assign word_out  = word_chain[fpa_pkg::DIV_STEPS];

endmodule
